// File: design/hexfr_pkg.sv
package hexfr_pkg;

   // Receiver mode
   typedef enum logic [1:0] {
      MODE_WAIT = 2'd0,
      MODE_HEX  = 2'd1,
      MODE_TEXT = 2'd2
   } mode_type;

   // Character codes
   localparam logic [7:0] CHAR_NUL   = 8'h00;
   localparam logic [7:0] CHAR_LF    = 8'h0A;
   localparam logic [7:0] CHAR_CR    = 8'h0D;
   localparam logic [7:0] CHAR_COLON = 8'h3A;
   localparam logic [7:0] PRINT_LO   = 8'h20;
   localparam logic [7:0] PRINT_HI   = 8'h7E;

   localparam logic [7:0] SUM_TARGET = 8'h55;

   localparam logic FRAME_HEX  = 1'b0;
   localparam logic FRAME_TEXT = 1'b1;

   // Classification of one received character
   typedef struct packed {
      logic       is_print;
      logic       is_lf;
      logic       is_cr;
      logic       is_colon;
      logic       is_nul;
      logic [3:0] nibble;
   } char_class_type;

   // One finished frame or line
   typedef struct packed {
      logic        frame_kind;
      logic [5:0]  char_count;
      logic [3:0]  command_nibble;
      logic [15:0] address;
      logic [7:0]  status_flags;
      logic [31:0] data_value;
      logic        checksum_ok;
      logic        overflowed;
   } result_type;

endpackage

// File: design/hexfr_ifs.sv
interface hexfr_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] byte_in;

   modport source (output valid, output byte_in, input ready);
   modport sink (input valid, input byte_in, output ready);
endinterface

interface hexfr_rsp_if;
   logic        valid;
   logic        ready;
   logic        frame_kind;
   logic [5:0]  char_count;
   logic [3:0]  command_nibble;
   logic [15:0] address;
   logic [7:0]  status_flags;
   logic [31:0] data_value;
   logic        checksum_ok;
   logic        overflowed;

   modport source (
      output valid, output frame_kind, output char_count, output command_nibble,
      output address, output status_flags, output data_value, output checksum_ok,
      output overflowed, input ready
   );
   modport sink (
      input valid, input frame_kind, input char_count, input command_nibble,
      input address, input status_flags, input data_value, input checksum_ok,
      input overflowed, output ready
   );
endinterface

// File: design/hexfr_char_class.sv
module hexfr_char_class
   import hexfr_pkg::*;
(
   input  logic [7:0]     char_in,
   output char_class_type char_class
);

   always_comb begin
      char_class.is_print = (char_in >= PRINT_LO) && (char_in <= PRINT_HI);
      char_class.is_lf    = (char_in == CHAR_LF);
      char_class.is_cr    = (char_in == CHAR_CR);
      char_class.is_colon = (char_in == CHAR_COLON);
      char_class.is_nul   = (char_in == CHAR_NUL);
      // non-hex characters decode as zero
      if (char_in >= 8'h30 && char_in <= 8'h39) begin
         char_class.nibble = char_in[3:0];
      end else if ((char_in >= 8'h41 && char_in <= 8'h46) ||
                   (char_in >= 8'h61 && char_in <= 8'h66)) begin
         char_class.nibble = 4'(char_in[2:0] + 3'd1) + 4'd8;
      end else begin
         char_class.nibble = 4'd0;
      end
   end

endmodule

// File: design/hexfr_frame_core.sv
module hexfr_frame_core
   import hexfr_pkg::*;
#(
   parameter int MAX_CHARS = 49
) (
   input  logic           clock,
   input  logic           reset,
   input  logic           accept,
   input  char_class_type char_class,
   output logic           result_valid,
   output result_type     result
);

   localparam int CW = $clog2(MAX_CHARS + 1);
   localparam int BW = CW - 1;
   localparam logic [CW-1:0] COUNT_MAX = CW'(MAX_CHARS);
   localparam logic [BW-1:0] BYTE_ADDR_LO = BW'(1);
   localparam logic [BW-1:0] BYTE_ADDR_HI = BW'(2);
   localparam logic [BW-1:0] BYTE_FLAGS   = BW'(3);
   localparam logic [BW-1:0] BYTE_DATA0   = BW'(4);
   localparam logic [BW-1:0] BYTE_DATA1   = BW'(5);
   localparam logic [BW-1:0] BYTE_DATA2   = BW'(6);
   localparam logic [BW-1:0] BYTE_DATA3   = BW'(7);

   mode_type      mode_ff, mode_in;
   logic [CW-1:0] count_ff, count_in;
   logic [7:0]    sum_ff, sum_in;
   logic [3:0]    held_ff, held_in;
   logic [3:0]    cmd_ff, cmd_in;
   logic [15:0]   addr_ff, addr_in;
   logic [7:0]    flags_ff, flags_in;
   logic [31:0]   data_ff, data_in;
   logic          ovf_ff, ovf_in;

   logic          emit;
   logic [BW-1:0] byte_idx;
   logic [7:0]    byte_val;

   assign byte_idx = count_ff[CW-1:1];
   assign byte_val = {held_ff, char_class.nibble};

   always_comb begin
      mode_in  = mode_ff;
      count_in = count_ff;
      sum_in   = sum_ff;
      held_in  = held_ff;
      cmd_in   = cmd_ff;
      addr_in  = addr_ff;
      flags_in = flags_ff;
      data_in  = data_ff;
      ovf_in   = ovf_ff;
      emit     = 1'b0;
      result   = '0;

      unique case (mode_ff)
         MODE_HEX: begin
            if (char_class.is_print) begin
               if (count_ff >= COUNT_MAX) begin
                  ovf_in = 1'b1;
               end else begin
                  count_in = count_ff + CW'(1);
                  if (count_ff == '0) begin
                     cmd_in = char_class.nibble;
                     sum_in = {4'd0, char_class.nibble};
                  end else if (count_ff[0]) begin
                     held_in = char_class.nibble;
                  end else begin
                     // complete a byte: add to sum, place by position
                     sum_in = sum_ff + byte_val;
                     unique case (byte_idx)
                        BYTE_ADDR_LO: addr_in[7:0]   = byte_val;
                        BYTE_ADDR_HI: addr_in[15:8]  = byte_val;
                        BYTE_FLAGS:   flags_in       = byte_val;
                        BYTE_DATA0:   data_in[7:0]   = data_ff[7:0] | byte_val;
                        BYTE_DATA1:   data_in[15:8]  = data_ff[15:8] | byte_val;
                        BYTE_DATA2:   data_in[23:16] = data_ff[23:16] | byte_val;
                        BYTE_DATA3:   data_in[31:24] = data_ff[31:24] | byte_val;
                        default: ;
                     endcase
                  end
               end
            end else if (char_class.is_lf) begin
               emit                  = 1'b1;
               result.frame_kind     = FRAME_HEX;
               result.char_count     = 6'(count_ff);
               result.command_nibble = cmd_ff;
               result.address        = addr_ff;
               result.status_flags   = flags_ff;
               result.data_value     = data_ff;
               // odd count means an even number of characters after the command
               result.checksum_ok    = count_ff[0] && (sum_ff == SUM_TARGET);
               result.overflowed     = ovf_ff;
               mode_in               = MODE_WAIT;
            end
         end
         MODE_TEXT: begin
            if (char_class.is_cr) begin
               emit              = 1'b1;
               result.frame_kind = FRAME_TEXT;
               result.char_count = 6'(count_ff);
               result.overflowed = ovf_ff;
               mode_in           = MODE_WAIT;
            end else if (char_class.is_lf || char_class.is_colon) begin
               count_in = '0;
               sum_in   = '0;
               held_in  = '0;
               cmd_in   = '0;
               addr_in  = '0;
               flags_in = '0;
               data_in  = '0;
               ovf_in   = 1'b0;
               if (char_class.is_colon) begin
                  mode_in = MODE_HEX;
               end
            end else if (!char_class.is_nul) begin
               if (count_ff >= COUNT_MAX) begin
                  ovf_in = 1'b1;
               end else begin
                  count_in = count_ff + CW'(1);
               end
            end
         end
         default: begin
            if (char_class.is_colon || char_class.is_lf) begin
               count_in = '0;
               sum_in   = '0;
               held_in  = '0;
               cmd_in   = '0;
               addr_in  = '0;
               flags_in = '0;
               data_in  = '0;
               ovf_in   = 1'b0;
               mode_in  = char_class.is_colon ? MODE_HEX : MODE_TEXT;
            end
         end
      endcase
   end

   assign result_valid = accept && emit;

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff  <= MODE_WAIT;
         count_ff <= '0;
         sum_ff   <= '0;
         held_ff  <= '0;
         cmd_ff   <= '0;
         addr_ff  <= '0;
         flags_ff <= '0;
         data_ff  <= '0;
         ovf_ff   <= 1'b0;
      end else if (accept) begin
         mode_ff  <= mode_in;
         count_ff <= count_in;
         sum_ff   <= sum_in;
         held_ff  <= held_in;
         cmd_ff   <= cmd_in;
         addr_ff  <= addr_in;
         flags_ff <= flags_in;
         data_ff  <= data_in;
         ovf_ff   <= ovf_in;
      end
   end

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= COUNT_MAX)
      else $error("character count beyond limit");

   a_ovf_full: assert property (@(posedge clock) disable iff (reset)
      ovf_ff |-> (count_ff == COUNT_MAX))
      else $error("overflow flagged with buffer not full");

   a_emit_wait: assert property (@(posedge clock) disable iff (reset)
      result_valid |=> (mode_ff == MODE_WAIT))
      else $error("mode not back to wait after a result");

endmodule

// File: design/hexfr_out_reg.sv
module hexfr_out_reg
   import hexfr_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       load,
   input  result_type load_data,
   output logic       space,
   output logic       out_valid,
   input  logic       out_ready,
   output result_type out_data
);

   logic       valid_ff, valid_in;
   result_type data_ff;

   // free when empty or when the held result leaves this cycle
   assign space = !valid_ff || out_ready;

   always_comb begin
      if (load) begin
         valid_in = 1'b1;
      end else if (out_ready) begin
         valid_in = 1'b0;
      end else begin
         valid_in = valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         data_ff <= load_data;
      end
   end

   assign out_valid = valid_ff;
   assign out_data  = data_ff;

   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      load |-> space)
      else $error("result loaded over a waiting result");

   a_text_no_sum: assert property (@(posedge clock) disable iff (reset)
      (valid_ff && data_ff.frame_kind == FRAME_TEXT) |->
         (!data_ff.checksum_ok && data_ff.address == '0))
      else $error("text line carries hex fields");

   a_load_shows: assert property (@(posedge clock) disable iff (reset)
      load |=> valid_ff)
      else $error("loaded result not presented");

endmodule

// File: design/hex_text_frame_receiver_top.sv
// Channel  Direction  Payload                                     Transfer when
// req_ch   in         byte_in[7:0]                                valid && ready
// rsp_ch   out        kind, count, cmd, addr, flags, data, ok, ov valid && ready
//
// One character per cycle while req_ch.ready is high: each transfer updates the
// frame state in one pass. A line feed (hex) or carriage return (text) loads a
// result into the output register at its transfer edge; rsp_ch.valid rises
// the cycle after. req_ch.ready is low only while a result waits and
// rsp_ch.ready is low. Synchronous reset returns to waiting for a start
// character, clears the frame state and empties the output register.
module hex_text_frame_receiver_top
   import hexfr_pkg::*;
#(
   parameter int MAX_CHARS = 49
) (
   input  logic         clock,
   input  logic         reset,
   hexfr_req_if.sink    req_ch,
   hexfr_rsp_if.source  rsp_ch
);

   char_class_type char_class;
   logic           accept;
   logic           space;
   logic           result_valid;
   result_type     result;
   result_type     out_data;

   // Take a new character whenever the output register can hold a result.
   assign req_ch.ready = space;
   assign accept       = req_ch.valid && space;

   // Classify the character and decode its hex value.
   hexfr_char_class u_class (
      .char_in    (req_ch.byte_in),
      .char_class (char_class)
   );

   // Mode, count, checksum and field assembly; produce a result on a terminator.
   hexfr_frame_core #(
      .MAX_CHARS (MAX_CHARS)
   ) u_core (
      .clock        (clock),
      .reset        (reset),
      .accept       (accept),
      .char_class   (char_class),
      .result_valid (result_valid),
      .result       (result)
   );

   // Hold the finished result until the sink takes it.
   hexfr_out_reg u_out (
      .clock     (clock),
      .reset     (reset),
      .load      (result_valid),
      .load_data (result),
      .space     (space),
      .out_valid (rsp_ch.valid),
      .out_ready (rsp_ch.ready),
      .out_data  (out_data)
   );

   // Drive the result payload.
   assign rsp_ch.frame_kind     = out_data.frame_kind;
   assign rsp_ch.char_count     = out_data.char_count;
   assign rsp_ch.command_nibble = out_data.command_nibble;
   assign rsp_ch.address        = out_data.address;
   assign rsp_ch.status_flags   = out_data.status_flags;
   assign rsp_ch.data_value     = out_data.data_value;
   assign rsp_ch.checksum_ok    = out_data.checksum_ok;
   assign rsp_ch.overflowed     = out_data.overflowed;

endmodule
